// ----- src/sdtcn_pkg.sv -----
// shared types and constants of the streaming dilated tcn block
// word widths, weight layout offsets, operation codes, datapath command struct
`timescale 1ns / 1ps

package sdtcn_pkg;

  localparam int CHANNELS    = 16;
  localparam int LAYERS      = 7;
  localparam int HIST        = 512;
  localparam int KT          = 3;
  localparam int IN_CH       = 6;
  localparam int OUT_CH      = 6;
  localparam int WT_WORDS    = 2048;

  // operation carried in tuser of an input transfer
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int OFF_IF1 = 0;
  localparam int OFF_IB1 = OFF_IF1 + CHANNELS * IN_CH * KT;
  localparam int OFF_IF2 = OFF_IB1 + CHANNELS;
  localparam int OFF_IB2 = OFF_IF2 + CHANNELS * KT;
  localparam int OFF_IRF = OFF_IB2 + CHANNELS;
  localparam int OFF_IRB = OFF_IRF + CHANNELS * IN_CH;
  localparam int OFF_HF1 = OFF_IRB + CHANNELS;
  localparam int OFF_HB1 = OFF_HF1 + (LAYERS - 1) * CHANNELS * KT;
  localparam int OFF_HF2 = OFF_HB1 + (LAYERS - 1) * CHANNELS;
  localparam int OFF_HB2 = OFF_HF2 + (LAYERS - 1) * CHANNELS * KT;
  localparam int OFF_OF  = OFF_HB2 + (LAYERS - 1) * CHANNELS;
  localparam int OFF_OB  = OFF_OF + OUT_CH * CHANNELS;

  typedef logic signed [15:0] word_t;
  typedef word_t [IN_CH-1:0]  samp_t;
  typedef word_t [OUT_CH-1:0] pred_t;

  typedef enum logic [1:0] {SRC_CONST, SRC_IN, SRC_MID, SRC_HID} src_t;
  typedef enum logic [2:0] {FIN_NONE, FIN_MID, FIN_V, FIN_RES0, FIN_HID, FIN_OUT} fin_t;

  typedef struct packed {
    logic        term;
    logic        first;
    logic [10:0] wt_addr;
    src_t        src;
    logic [11:0] in_addr;
    logic [15:0] hs_addr;
    logic        capture;
    fin_t        fin;
    logic [15:0] wr_addr;
    logic [2:0]  out_idx;
    logic        push;
    logic [2:0]  push_ic;
    logic        load;
    logic        wt_we;
  } cmd_t;

endpackage

// ----- src/sdtcn_dp.sv -----
// datapath: weight and activation memories, shared multiply-accumulate, finish logic
// driven by sdtcn_ctrl through sdtcn_pkg::cmd_t
`timescale 1ns / 1ps

module sdtcn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sdtcn_pkg::cmd_t    cmd,
  input  logic [10:0]        weight_addr,
  input  sdtcn_pkg::word_t   weight_value,
  input  sdtcn_pkg::samp_t   samples,
  output sdtcn_pkg::pred_t   pred
);
  import sdtcn_pkg::*;

  word_t wmem [0:WT_WORDS-1];
  word_t imem [0:IN_CH*HIST-1];
  word_t mmem [0:LAYERS*CHANNELS*HIST-1];
  word_t hmem [0:LAYERS*CHANNELS*HIST-1];

  word_t w_rd_r, i_rd_r, m_rd_r, h_rd_r;
  samp_t samp_r;
  pred_t pred_r;
  word_t v_r, skip_r;

  logic  s1_term_r, s1_first_r, s1_capture_r;
  src_t  s1_src_r;
  logic  s2_term_r, s2_first_r;
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;

  word_t act;
  logic signed [39:0] acc_rnd;
  logic signed [27:0] rnd;
  word_t sat_rnd, relu_v, fin_res0, fin_hid;

  function automatic word_t sat29(input logic signed [28:0] v);
    if (v > 29'sd32767) return 16'sh7fff;
    else if (v < -29'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  always_comb begin
    case (s1_src_r)
      SRC_CONST: act = 16'sd4096;
      SRC_IN:    act = i_rd_r;
      SRC_MID:   act = m_rd_r;
      SRC_HID:   act = h_rd_r;
      default:   act = 16'sd0;
    endcase
    acc_rnd  = acc_r + 40'sd2048;
    rnd      = acc_rnd[39:12];
    sat_rnd  = sat29(29'(rnd));
    relu_v   = sat_rnd[15] ? 16'sd0 : sat_rnd;
    fin_res0 = sat29(29'(v_r) + 29'(rnd));
    fin_hid  = sat29(29'(relu_v) + 29'(skip_r));
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.wt_we) wmem[weight_addr] <= weight_value;
    w_rd_r <= wmem[cmd.wt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) imem[cmd.in_addr] <= samp_r[cmd.push_ic];
    i_rd_r <= imem[cmd.in_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin == FIN_MID) mmem[cmd.wr_addr] <= relu_v;
    m_rd_r <= mmem[cmd.hs_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin == FIN_RES0) hmem[cmd.wr_addr] <= fin_res0;
    else if (cmd.fin == FIN_HID) hmem[cmd.wr_addr] <= fin_hid;
    h_rd_r <= hmem[cmd.hs_addr];
  end

  // mac pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_term_r <= 1'b0;
      s1_first_r <= 1'b0;
      s1_capture_r <= 1'b0;
      s2_term_r <= 1'b0;
      s2_first_r <= 1'b0;
    end else begin
      s1_term_r <= cmd.term;
      s1_first_r <= cmd.first;
      s1_capture_r <= cmd.capture;
      s2_term_r <= s1_term_r;
      s2_first_r <= s1_first_r;
    end
  end

  // mac payload
  always_ff @(posedge clk) begin
    s1_src_r <= cmd.src;
    prod_r <= w_rd_r * act;
    if (s2_term_r) acc_r <= s2_first_r ? 40'(prod_r) : acc_r + 40'(prod_r);
    if (s1_capture_r) skip_r <= h_rd_r;
    if (cmd.load) samp_r <= samples;
    if (cmd.fin == FIN_V) v_r <= relu_v;
    if (cmd.fin == FIN_OUT) pred_r[cmd.out_idx] <= sat_rnd;
  end

  assign pred = pred_r;

endmodule

// ----- src/sdtcn_ctrl.sv -----
// controller: sequences weight loads, sample push and every layer's dot products
// issues sdtcn_pkg::cmd_t to sdtcn_dp, holds ring head and history count
`timescale 1ns / 1ps

module sdtcn_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            op,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            warm,
  output sdtcn_pkg::cmd_t cmd
);
  import sdtcn_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_PUSH, ST_TERM, ST_DRAIN, ST_FIN, ST_DONE} st_t;
  typedef enum logic [2:0] {PH_L0A, PH_L0B, PH_L0R, PH_HA, PH_HB, PH_OUT} ph_t;

  st_t        st_r;
  ph_t        ph_r;
  logic [3:0] ch_r, a_r;
  logic [2:0] l_r;
  logic [1:0] tap_r;
  logic       sub_r, drn_r, warm_r;
  logic [8:0] head_r;
  logic [9:0] seen_r;

  logic [3:0] a_max;
  logic [1:0] tap_max;
  logic [7:0] dil, dly;
  logic       tap_ok;
  logic [8:0] pos;
  logic [2:0] lm1;
  int         chi, ai, kw, fi;

  always_comb begin
    case (ph_r)
      PH_L0A:  begin a_max = 4'(IN_CH - 1);    tap_max = 2'(KT - 1); end
      PH_L0R:  begin a_max = 4'(IN_CH - 1);    tap_max = 2'd0;       end
      PH_OUT:  begin a_max = 4'(CHANNELS - 1); tap_max = 2'd0;       end
      default: begin a_max = 4'd0;             tap_max = 2'(KT - 1); end
    endcase
    dil = 8'd1 << l_r;
    case (tap_r)
      2'd0:    dly = 8'd0;
      2'd1:    dly = dil;
      default: dly = dil << 1;
    endcase
    tap_ok = {2'b00, dly} < seen_r;
    pos = head_r - {1'b0, dly};
    lm1 = l_r - 3'd1;
    chi = int'(ch_r);
    ai  = int'(a_r);
    kw  = KT - 1 - int'(tap_r);
    fi  = int'(lm1);

    cmd = '0;
    cmd.src = SRC_CONST;
    cmd.fin = FIN_NONE;
    case (st_r)
      ST_IDLE: begin
        cmd.wt_we = in_tvalid & ~op;
        cmd.load  = in_tvalid & op;
      end
      ST_PUSH: begin
        cmd.push    = 1'b1;
        cmd.push_ic = a_r[2:0];
        cmd.in_addr = {a_r[2:0], head_r};
      end
      ST_TERM: begin
        cmd.term  = sub_r ? tap_ok : 1'b1;
        cmd.first = ~sub_r;
        case (ph_r)
          PH_L0A: begin
            cmd.wt_addr = sub_r ? 11'(OFF_IF1 + (chi * IN_CH + ai) * KT + kw)
                                : 11'(OFF_IB1 + chi);
            cmd.src     = sub_r ? SRC_IN : SRC_CONST;
            cmd.in_addr = {a_r[2:0], pos};
          end
          PH_L0B: begin
            cmd.wt_addr = sub_r ? 11'(OFF_IF2 + chi * KT + kw) : 11'(OFF_IB2 + chi);
            cmd.src     = sub_r ? SRC_MID : SRC_CONST;
            cmd.hs_addr = {3'd0, ch_r, pos};
          end
          PH_L0R: begin
            cmd.wt_addr = sub_r ? 11'(OFF_IRF + chi * IN_CH + ai) : 11'(OFF_IRB + chi);
            cmd.src     = sub_r ? SRC_IN : SRC_CONST;
            cmd.in_addr = {a_r[2:0], head_r};
          end
          PH_HA: begin
            cmd.wt_addr = sub_r ? 11'(OFF_HF1 + (fi * CHANNELS + chi) * KT + kw)
                                : 11'(OFF_HB1 + fi * CHANNELS + chi);
            cmd.src     = sub_r ? SRC_HID : SRC_CONST;
            cmd.hs_addr = {lm1, ch_r, pos};
          end
          PH_HB: begin
            cmd.wt_addr = sub_r ? 11'(OFF_HF2 + (fi * CHANNELS + chi) * KT + kw)
                                : 11'(OFF_HB2 + fi * CHANNELS + chi);
            cmd.src     = sub_r ? SRC_MID : SRC_CONST;
            // bias cycle also fetches the identity residual
            cmd.capture = ~sub_r;
            cmd.hs_addr = sub_r ? {l_r, ch_r, pos} : {lm1, ch_r, head_r};
          end
          default: begin
            cmd.wt_addr = sub_r ? 11'(OFF_OF + chi * CHANNELS + ai) : 11'(OFF_OB + chi);
            cmd.src     = sub_r ? SRC_HID : SRC_CONST;
            cmd.hs_addr = {3'(LAYERS - 1), a_r, head_r};
          end
        endcase
      end
      ST_FIN: begin
        cmd.out_idx = ch_r[2:0];
        case (ph_r)
          PH_L0A:  begin cmd.fin = FIN_MID;  cmd.wr_addr = {3'd0, ch_r, head_r}; end
          PH_L0B:  cmd.fin = FIN_V;
          PH_L0R:  begin cmd.fin = FIN_RES0; cmd.wr_addr = {3'd0, ch_r, head_r}; end
          PH_HA:   begin cmd.fin = FIN_MID;  cmd.wr_addr = {l_r, ch_r, head_r}; end
          PH_HB:   begin cmd.fin = FIN_HID;  cmd.wr_addr = {l_r, ch_r, head_r}; end
          default: cmd.fin = FIN_OUT;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ph_r   <= PH_L0A;
      ch_r   <= 4'd0;
      a_r    <= 4'd0;
      l_r    <= 3'd0;
      tap_r  <= 2'd0;
      sub_r  <= 1'b0;
      drn_r  <= 1'b0;
      warm_r <= 1'b0;
      head_r <= 9'(HIST - 1);
      seen_r <= 10'd0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (in_tvalid && op) begin
            warm_r <= seen_r >= 10'(HIST);
            head_r <= head_r + 9'd1;
            if (seen_r < 10'(HIST)) seen_r <= seen_r + 10'd1;
            a_r  <= 4'd0;
            st_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (a_r == 4'(IN_CH - 1)) begin
            a_r   <= 4'd0;
            tap_r <= 2'd0;
            sub_r <= 1'b0;
            ch_r  <= 4'd0;
            l_r   <= 3'd0;
            ph_r  <= PH_L0A;
            st_r  <= ST_TERM;
          end else begin
            a_r <= a_r + 4'd1;
          end
        end
        ST_TERM: begin
          if (!sub_r) begin
            sub_r <= 1'b1;
            a_r   <= 4'd0;
            tap_r <= 2'd0;
          end else if (tap_r == tap_max) begin
            tap_r <= 2'd0;
            if (a_r == a_max) begin
              drn_r <= 1'b0;
              st_r  <= ST_DRAIN;
            end else begin
              a_r <= a_r + 4'd1;
            end
          end else begin
            tap_r <= tap_r + 2'd1;
          end
        end
        ST_DRAIN: begin
          if (drn_r) st_r <= ST_FIN;
          else drn_r <= 1'b1;
        end
        ST_FIN: begin
          sub_r <= 1'b0;
          st_r  <= ST_TERM;
          case (ph_r)
            PH_L0A: begin
              if (ch_r == 4'(CHANNELS - 1)) begin
                ch_r <= 4'd0;
                ph_r <= PH_L0B;
              end else ch_r <= ch_r + 4'd1;
            end
            PH_L0B: ph_r <= PH_L0R;
            PH_L0R: begin
              if (ch_r == 4'(CHANNELS - 1)) begin
                ch_r <= 4'd0;
                l_r  <= 3'd1;
                ph_r <= PH_HA;
              end else begin
                ch_r <= ch_r + 4'd1;
                ph_r <= PH_L0B;
              end
            end
            PH_HA: begin
              if (ch_r == 4'(CHANNELS - 1)) begin
                ch_r <= 4'd0;
                ph_r <= PH_HB;
              end else ch_r <= ch_r + 4'd1;
            end
            PH_HB: begin
              if (ch_r == 4'(CHANNELS - 1)) begin
                ch_r <= 4'd0;
                if (l_r == 3'(LAYERS - 1)) ph_r <= PH_OUT;
                else begin
                  l_r  <= l_r + 3'd1;
                  ph_r <= PH_HA;
                end
              end else ch_r <= ch_r + 4'd1;
            end
            default: begin
              if (ch_r == 4'(OUT_CH - 1)) st_r <= ST_DONE;
              else ch_r <= ch_r + 4'd1;
            end
          endcase
        end
        ST_DONE: begin
          if (out_tready) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_DONE);
  assign warm       = warm_r;

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= 10'(HIST)) else $error("history count past depth");
  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && op) |=> (head_r == $past(head_r) + 9'd1) && st_r == ST_PUSH)
    else $error("sample accept did not advance ring head");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !op) |=> st_r == ST_IDLE && $stable(head_r))
    else $error("weight load disturbed sequencer");
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) |-> $past(st_r) == ST_DRAIN && $past(st_r, 2) == ST_DRAIN)
    else $error("finish before mac pipeline drained");
endmodule

// ----- src/streaming_dilated_tcn_inference.sv -----
// top level of the streaming dilated tcn block
// a weight load transfer gives no result; a sample transfer gives its prediction once the
// six input channels are pushed and every layer's dot products are computed by the one shared
// multiply-accumulate unit doing one term per cycle, with a drain of its pipeline per dot product
// a new transfer is not accepted until the prediction has been taken with out_tready
// reset: synchronous active-low; clears sequencer, ring head to 511 and history count to 0;
// weight and activation memories hold no reset value and are undefined until written
`timescale 1ns / 1ps

module streaming_dilated_tcn_inference (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fields from bit 0: weight_addr[10:0], weight_value[26:11], sample_ch0..ch5 16 bits each
  // from bit 27, zero fill to 128
  input  logic [127:0] in_tdata,
  // fields: op (0 weight load, 1 sample)
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fields from bit 0: pred_ch0..pred_ch5, 16 bits each
  output logic [95:0]  out_tdata,
  // fields: warm
  output logic         out_tuser
);
  import sdtcn_pkg::*;

  cmd_t  cmd;
  samp_t samples;
  pred_t pred;

  // unpack the sample channels of one transfer
  always_comb begin
    for (int i = 0; i < IN_CH; i++) begin
      samples[i] = in_tdata[27 + 16*i +: 16];
    end
  end

  sdtcn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .op         (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .warm       (out_tuser),
    .cmd        (cmd)
  );

  sdtcn_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .weight_addr  (in_tdata[10:0]),
    .weight_value (in_tdata[26:11]),
    .samples      (samples),
    .pred         (pred)
  );

  // predictions are held in the datapath until the result transfer completes
  assign out_tdata = pred;

endmodule

// ----- tb/tb_streaming_dilated_tcn_inference_checker.sv -----
// checker of the streaming dilated tcn block: watches both stream channels,
// keeps its own weight and activation memories and compares every prediction
// depends on sdtcn_pkg for widths, operation codes and weight layout offsets
`timescale 1ns / 1ps

module tb_streaming_dilated_tcn_inference_checker
  import sdtcn_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef enum int {HS_IN, HS_MID, HS_HID} hsel_e;

  typedef struct {
    shortint pred [OUT_CH];
    bit      warm;
  } prediction_t;

  shortint     wmem [WT_WORDS];
  shortint     in_h [IN_CH][HIST];
  shortint     mid_h [LAYERS][CHANNELS][HIST];
  shortint     hid_h [LAYERS][CHANNELS][HIST];
  int          head;
  int          seen;
  prediction_t pred_q [$];

  function automatic longint rnd12(longint a);
    return (a + 2048) >>> 12;
  endfunction

  function automatic shortint sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return shortint'(v);
  endfunction

  function automatic shortint relu(shortint v);
    return v < 0 ? 16'sd0 : v;
  endfunction

  function automatic longint wt(int a);
    return longint'(wmem[a]);
  endfunction

  // causal dilated taps, skipping those older than the history seen
  function automatic longint dil_conv(hsel_e src, int l, int ch, int kbase, int d);
    longint  acc;
    int      dly;
    int      pos;
    shortint x;
    acc = 0;
    for (int i = 0; i < KT; i++) begin
      dly = d * i;
      if (dly >= seen) break;
      pos = (head + HIST - dly) % HIST;
      case (src)
        HS_IN:   x = in_h[ch][pos];
        HS_MID:  x = mid_h[l][ch][pos];
        default: x = hid_h[l][ch][pos];
      endcase
      acc += wt(kbase + KT - 1 - i) * longint'(x);
    end
    return acc;
  endfunction

  function automatic prediction_t run_network(logic [127:0] d);
    prediction_t p;
    longint      acc;
    longint      res;
    shortint     v;
    int          h;
    int          f;
    p.warm = seen >= HIST;
    head = (head + 1) % HIST;
    if (seen < HIST) seen++;
    h = head;
    for (int ic = 0; ic < IN_CH; ic++) in_h[ic][h] = shortint'(d[27 + 16 * ic +: 16]);
    // input layer: mixing conv, then depthwise conv with projected residual
    for (int oc = 0; oc < CHANNELS; oc++) begin
      acc = wt(OFF_IB1 + oc) * 4096;
      for (int ic = 0; ic < IN_CH; ic++)
        acc += dil_conv(HS_IN, 0, ic, OFF_IF1 + (oc * IN_CH + ic) * KT, 1);
      mid_h[0][oc][h] = relu(sat16(rnd12(acc)));
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = wt(OFF_IB2 + ch) * 4096 + dil_conv(HS_MID, 0, ch, OFF_IF2 + ch * KT, 1);
      res = wt(OFF_IRB + ch) * 4096;
      v = relu(sat16(rnd12(acc)));
      for (int ic = 0; ic < IN_CH; ic++)
        res += wt(OFF_IRF + ch * IN_CH + ic) * longint'(in_h[ic][h]);
      hid_h[0][ch][h] = sat16(longint'(v) + rnd12(res));
    end
    // hidden layers with identity residual
    for (int l = 1; l < LAYERS; l++) begin
      f = l - 1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        acc = wt(OFF_HB1 + f * CHANNELS + ch) * 4096
            + dil_conv(HS_HID, l - 1, ch, OFF_HF1 + (f * CHANNELS + ch) * KT, 1 << l);
        mid_h[l][ch][h] = relu(sat16(rnd12(acc)));
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
        acc = wt(OFF_HB2 + f * CHANNELS + ch) * 4096
            + dil_conv(HS_MID, l, ch, OFF_HF2 + (f * CHANNELS + ch) * KT, 1 << l);
        v = relu(sat16(rnd12(acc)));
        hid_h[l][ch][h] = sat16(longint'(v) + longint'(hid_h[l - 1][ch][h]));
      end
    end
    for (int oc = 0; oc < OUT_CH; oc++) begin
      acc = wt(OFF_OB + oc) * 4096;
      for (int ic = 0; ic < CHANNELS; ic++)
        acc += wt(OFF_OF + oc * CHANNELS + ic) * longint'(hid_h[LAYERS - 1][ic][h]);
      p.pred[oc] = sat16(rnd12(acc));
    end
    return p;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    head       = HIST - 1;
    seen       = 0;
    foreach (wmem[i]) wmem[i] = 0;
  end

  always @(posedge clk) begin
    prediction_t e;
    shortint     got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_LOAD) wmem[in_tdata[10:0]] = shortint'(in_tdata[26:11]);
        else pred_q.insert(pred_q.size(), run_network(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (pred_q.size() == 0) begin
          $display("%0t: unexpected prediction transfer %h warm %b", $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          e = pred_q.pop_front();
          for (int oc = 0; oc < OUT_CH; oc++) begin
            got = shortint'(out_tdata[16 * oc +: 16]);
            if (got != e.pred[oc]) begin
              $display("%0t: pred_ch%0d expected %0d actual %0d", $time, oc, e.pred[oc], got);
              fail_count++;
            end
          end
          if (out_tuser != e.warm) begin
            $display("%0t: warm expected %0d actual %0d", $time, e.warm, out_tuser);
            fail_count++;
          end
        end
      end
      pending = pred_q.size();
    end
  end

endmodule

// ----- tb/tb_streaming_dilated_tcn_inference.sv -----
// testbench top of the streaming dilated tcn block: clock, reset, weight loads
// and sample stimulus with bursty sender and stalling receiver, final verdict
// depends on sdtcn_pkg, the block and tb_streaming_dilated_tcn_inference_checker
`timescale 1ns / 1ps

module tb_streaming_dilated_tcn_inference;
  import sdtcn_pkg::*;

  localparam int   LAYOUT_WORDS = OFF_OB + OUT_CH;  // 1350 words in use
  localparam int   RAND_SAMPLES = 540;              // enough to reach warm history
  localparam int   LONG_HOLD    = 8000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending;

  // long receiver hold-off handshake between stimulus and receiver processes
  logic         hold_go = 1'b0;
  logic         hold_done = 1'b0;
  int           burst_left = 0;

  always #10 clk = ~clk;

  streaming_dilated_tcn_inference u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  tb_streaming_dilated_tcn_inference_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // one transfer on the input channel; gaps only open between bursts
  task automatic send(logic op, logic [10:0] addr, logic [15:0] val, samp_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, s, val, addr};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // mostly moderate values so activations stay inside range, sometimes full scale
  function automatic logic [15:0] rand_word(int span);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic samp_t rand_sample();
    samp_t s;
    for (int i = 0; i < IN_CH; i++) s[i] = rand_word(8192);
    return s;
  endfunction

  function automatic samp_t fill_sample(logic [15:0] v);
    samp_t s;
    for (int i = 0; i < IN_CH; i++) s[i] = v;
    return s;
  endfunction

  // receiver: random ready/stall pattern, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done <= 1'b1;
        @(posedge clk);
      end
      n = $urandom_range(1, 40);
      out_tready <= 1'b1;
      repeat (n) @(posedge clk);
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    samp_t       z;
    int          sent;
    int          r;
    logic [15:0] keep0;
    z = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full weight image first, so no sample ever reads an unwritten word
    for (int a = 0; a < LAYOUT_WORDS; a++) begin
      if (a == 0) keep0 = 16'($urandom_range(0, 2048) - 1024);
      send(OP_LOAD, 11'(a), (a == 0) ? keep0 : 16'($urandom_range(0, 2048) - 1024),
           rand_sample());
    end

    // directed: short history, extreme samples, extreme weights, unused addresses
    send(OP_SAMPLE, '0, '0, z);
    send(OP_SAMPLE, '0, '0, fill_sample(16'h7fff));
    send(OP_SAMPLE, '0, '0, fill_sample(16'h8000));
    send(OP_SAMPLE, 11'h7ff, 16'hffff, fill_sample(16'h7fff));
    send(OP_LOAD, 11'h7ff, 16'h8000, z);
    send(OP_LOAD, 11'(LAYOUT_WORDS), 16'h7fff, z);
    send(OP_LOAD, 11'd0, 16'h7fff, z);
    send(OP_LOAD, 11'(OFF_OB), 16'h8000, z);
    send(OP_SAMPLE, '0, '0, fill_sample(16'h7fff));
    send(OP_SAMPLE, '0, '0, fill_sample(16'h8000));
    send(OP_LOAD, 11'(OFF_OB), 16'h7fff, z);
    send(OP_SAMPLE, '0, '0, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send(OP_LOAD, 11'd0, keep0, z);
    send(OP_LOAD, 11'(OFF_OB), 16'd0, z);
    send(OP_SAMPLE, '0, '0, z);

    // random part: weight rewrites interleaved with samples
    sent = 0;
    while (sent < RAND_SAMPLES) begin
      if (sent == 40 && !hold_go) begin
        // receiver holds off while samples keep coming, so the input stalls
        hold_go <= 1'b1;
        for (int k = 0; k < 4; k++) send(OP_SAMPLE, 11'($urandom), 16'($urandom), rand_sample());
        sent += 4;
        wait (hold_done);
      end
      if (sent == 200) begin
        // sender quiet until every prediction is back
        in_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send(OP_LOAD, 11'($urandom_range(0, LAYOUT_WORDS - 1)), rand_word(1536), rand_sample());
      end else if (r < 58) begin
        send(OP_LOAD, 11'($urandom_range(LAYOUT_WORDS, WT_WORDS - 1)), 16'($urandom),
             rand_sample());
      end else begin
        send(OP_SAMPLE, 11'($urandom), 16'($urandom), rand_sample());
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit well beyond the slowest correct run
  initial begin
    #150_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
